### design/snll_pkg.sv
// Shared types, widths and table generation functions for the sigmoid neuron with log loss.
package snll_pkg;

    localparam int unsigned DATA_W        = 16;
    localparam int unsigned PROD_W        = 32;
    localparam int unsigned ACC_W         = 40;
    localparam int unsigned SIX_SHIFT     = 20;
    localparam int unsigned OUT_W         = 16;
    localparam int unsigned SIG_DEPTH_DEF  = 256;
    localparam int unsigned LOSS_DEPTH_DEF = 256;

    typedef logic [63:0]             t_u64;
    typedef logic signed [ACC_W-1:0] t_acc;

    typedef struct packed {
        t_acc sum;
        logic label;
        logic sat;
    } t_sum_item;

    typedef struct packed {
        logic [OUT_W-1:0] act;
        logic             label;
        logic             sat;
    } t_act_item;

    localparam t_u64 Q62_ONE = 64'h4000_0000_0000_0000;

    function automatic t_u64 udiv(input t_u64 num, input t_u64 den);
        t_u64        quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic t_u64 mul_q62(input t_u64 a, input t_u64 b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic t_u64 div_q62(input t_u64 num, input t_u64 den);
        t_u64 a;
        t_u64 hi;
        t_u64 r;
        a  = num << 31;
        hi = udiv(a, den);
        r  = a - hi * den;
        return (hi << 31) + udiv(r << 31, den);
    endfunction

    function automatic t_u64 atanh_q62(input t_u64 z);
        t_u64 z2;
        t_u64 t;
        t_u64 s;
        z2 = mul_q62(z, z);
        t  = z;
        s  = '0;
        for (int k = 0; k < 32; k++) begin
            s = s + udiv(t, t_u64'(2 * k + 1));
            t = mul_q62(t, z2);
        end
        return s;
    endfunction

    function automatic t_u64 exp_neg_32nd();
        t_u64 e1;
        t_u64 term;
        e1   = Q62_ONE;
        term = Q62_ONE;
        for (int n = 1; n < 25; n++) begin
            term = udiv(term, t_u64'(32 * n));
            if ((n % 2) == 1) begin
                e1 = e1 - term;
            end else begin
                e1 = e1 + term;
            end
        end
        return e1;
    endfunction

    function automatic logic [OUT_W-1:0] sig_entry(input int k, input int depth);
        t_u64 e1;
        t_u64 p;
        t_u64 d;
        t_u64 q;
        t_u64 v;
        int   m2;
        int   m;
        e1 = exp_neg_32nd();
        m2 = 2 * k - (depth - 1);
        m  = (m2 < 0) ? -m2 : m2;
        if (m >= depth) begin
            m = depth - 1;
        end
        p = Q62_ONE;
        for (int i = 0; i < m; i++) begin
            p = mul_q62(p, e1);
        end
        d = (Q62_ONE + p) >> 30;
        q = udiv(t_u64'(65535) << 47, d);
        if (m2 >= 0) begin
            v = (q + (t_u64'(1) << 14)) >> 15;
        end else begin
            v = (((t_u64'(65535) << 15) - q) + (t_u64'(1) << 14)) >> 15;
        end
        if (v > t_u64'(65535)) begin
            v = t_u64'(65535);
        end
        return v[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] loss_entry(input int j, input int depth);
        t_u64 ln2_q40;
        t_u64 a;
        t_u64 c;
        t_u64 sh;
        t_u64 v;
        ln2_q40 = (atanh_q62(div_q62(t_u64'(1), t_u64'(3))) << 1) >> 22;
        a  = t_u64'(2 * depth);
        c  = t_u64'(2 * j + 1);
        sh = '0;
        for (int i = 0; i < 16; i++) begin
            if ((c << 1) <= a) begin
                c  = c << 1;
                sh = sh + t_u64'(1);
            end
        end
        v = sh * ln2_q40 + ((atanh_q62(div_q62(a - c, a + c)) << 1) >> 22);
        v = (v + (t_u64'(1) << 28)) >> 29;
        if (v > t_u64'(65535)) begin
            v = t_u64'(65535);
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

### design/snll_mac.sv
// Input register, product stage and saturating accumulator that emits the sum of each vector.
module snll_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [snll_pkg::DATA_W-1:0]   i_weight,
    input  logic signed [snll_pkg::DATA_W-1:0]   i_feature,
    input  logic                                 i_label,
    input  logic                                 i_last,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output snll_pkg::t_sum_item                  o_item
);

    localparam int unsigned ACC_W  = snll_pkg::ACC_W;
    localparam int unsigned PROD_W = snll_pkg::PROD_W;

    logic                                r_a_valid;
    logic signed [snll_pkg::DATA_W-1:0]  r_a_weight;
    logic signed [snll_pkg::DATA_W-1:0]  r_a_feature;
    logic                                r_a_label;
    logic                                r_a_last;

    logic                                r_b_valid;
    logic signed [PROD_W-1:0]            r_b_prod;
    logic                                r_b_label;
    logic                                r_b_last;

    logic                                r_c_valid;
    snll_pkg::t_sum_item                 r_c_item;

    snll_pkg::t_acc                      r_acc;
    logic                                r_sat;

    logic                                w_c_take;
    logic                                w_b_adv;
    logic                                w_b_free;
    logic                                w_a_adv;
    logic                                w_a_free;
    logic                                w_accept;
    logic signed [ACC_W:0]               w_sum_wide;
    logic                                w_ovf;
    snll_pkg::t_acc                      w_sum_sat;

    logic                                n_a_valid;
    logic                                n_b_valid;
    logic                                n_c_valid;
    snll_pkg::t_acc                      n_acc;
    logic                                n_sat;

    assign w_c_take = !r_c_valid || i_ready;
    assign w_b_adv  = r_b_valid && (!r_b_last || w_c_take);
    assign w_b_free = !r_b_valid || w_b_adv;
    assign w_a_adv  = r_a_valid && w_b_free;
    assign w_a_free = !r_a_valid || w_a_adv;
    assign w_accept = i_valid && w_a_free;
    assign o_ready  = w_a_free;

    assign w_sum_wide = {r_acc[ACC_W-1], r_acc}
                      + {{(ACC_W + 1 - PROD_W){r_b_prod[PROD_W-1]}}, r_b_prod};
    assign w_ovf      = w_sum_wide[ACC_W] != w_sum_wide[ACC_W-1];

    always_comb begin
        if (w_ovf) begin
            w_sum_sat = w_sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                          : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            w_sum_sat = w_sum_wide[ACC_W-1:0];
        end
    end

    always_comb begin
        n_a_valid = w_accept || (r_a_valid && !w_a_adv);
        n_b_valid = w_a_adv || (r_b_valid && !w_b_adv);
        n_c_valid = (w_b_adv && r_b_last) || (r_c_valid && !i_ready);
        n_acc     = r_acc;
        n_sat     = r_sat;
        if (w_b_adv) begin
            if (r_b_last) begin
                n_acc = '0;
                n_sat = 1'b0;
            end else begin
                n_acc = w_sum_sat;
                n_sat = r_sat || w_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_acc     <= '0;
            r_sat     <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
            r_c_valid <= n_c_valid;
            r_acc     <= n_acc;
            r_sat     <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_weight  <= i_weight;
            r_a_feature <= i_feature;
            r_a_label   <= i_label;
            r_a_last    <= i_last;
        end
        if (w_a_adv) begin
            r_b_prod  <= PROD_W'(r_a_weight) * PROD_W'(r_a_feature);
            r_b_label <= r_a_label;
            r_b_last  <= r_a_last;
        end
        if (w_b_adv && r_b_last) begin
            r_c_item.sum   <= w_sum_sat;
            r_c_item.label <= r_b_label;
            r_c_item.sat   <= r_sat || w_ovf;
        end
    end

    assign o_valid = r_c_valid;
    assign o_item  = r_c_item;

endmodule

### design/snll_sig.sv
// Sigmoid stage: clamps the sum in sixteenths to the table range and registers the activation.
module snll_sig #(
    parameter int unsigned SIGMOID_TABLE_DEPTH = snll_pkg::SIG_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  snll_pkg::t_sum_item i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output snll_pkg::t_act_item o_item
);

    localparam int unsigned IDX_W = $clog2(SIGMOID_TABLE_DEPTH);
    localparam int unsigned SIX_W = snll_pkg::ACC_W - snll_pkg::SIX_SHIFT;

    logic [snll_pkg::OUT_W-1:0] w_tab [SIGMOID_TABLE_DEPTH];

    for (genvar g_k = 0; g_k < SIGMOID_TABLE_DEPTH; g_k++) begin : g_tab
        localparam logic [snll_pkg::OUT_W-1:0] ENTRY =
            snll_pkg::sig_entry(g_k, SIGMOID_TABLE_DEPTH);
        assign w_tab[g_k] = ENTRY;
    end

    logic                    r_valid;
    snll_pkg::t_act_item     r_item;
    logic                    w_take;
    logic                    w_accept;
    logic signed [SIX_W-1:0] w_six;
    logic signed [SIX_W:0]   w_idx_wide;
    logic [IDX_W-1:0]        w_idx;

    assign w_take   = !r_valid || i_ready;
    assign w_accept = i_valid && w_take;
    assign o_ready  = w_take;

    assign w_six      = i_item.sum[snll_pkg::ACC_W-1 -: SIX_W];
    assign w_idx_wide = {w_six[SIX_W-1], w_six} + (SIX_W + 1)'(SIGMOID_TABLE_DEPTH / 2);

    always_comb begin
        priority if (w_idx_wide[SIX_W]) begin
            w_idx = '0;
        end else if (w_idx_wide > (SIX_W + 1)'(SIGMOID_TABLE_DEPTH - 1)) begin
            w_idx = IDX_W'(SIGMOID_TABLE_DEPTH - 1);
        end else begin
            w_idx = w_idx_wide[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept || (r_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.act   <= w_tab[w_idx];
            r_item.label <= i_item.label;
            r_item.sat   <= i_item.sat;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### design/snll_loss.sv
// Loss stage: selects the probability of the true class, looks up the log loss and holds the result.
module snll_loss #(
    parameter int unsigned LOSS_TABLE_DEPTH = snll_pkg::LOSS_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  snll_pkg::t_act_item        i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [snll_pkg::OUT_W-1:0] o_activation,
    output logic [snll_pkg::OUT_W-1:0] o_loss,
    output logic                       o_saturated
);

    localparam int unsigned OUT_W  = snll_pkg::OUT_W;
    localparam int unsigned LIDX_W = $clog2(LOSS_TABLE_DEPTH);
    localparam int unsigned LMUL_W = $clog2(LOSS_TABLE_DEPTH + 1);

    logic [OUT_W-1:0] w_tab [LOSS_TABLE_DEPTH];

    for (genvar g_j = 0; g_j < LOSS_TABLE_DEPTH; g_j++) begin : g_tab
        localparam logic [OUT_W-1:0] ENTRY = snll_pkg::loss_entry(g_j, LOSS_TABLE_DEPTH);
        assign w_tab[g_j] = ENTRY;
    end

    logic                      r_valid;
    logic [OUT_W-1:0]          r_activation;
    logic [OUT_W-1:0]          r_loss;
    logic                      r_saturated;
    logic                      w_take;
    logic                      w_accept;
    logic [OUT_W-1:0]          w_q;
    logic [OUT_W+LMUL_W-1:0]   w_prod;
    logic [LIDX_W-1:0]         w_lidx;

    assign w_take   = !r_valid || i_ready;
    assign w_accept = i_valid && w_take;
    assign o_ready  = w_take;

    assign w_q    = i_item.label ? i_item.act : ~i_item.act;
    assign w_prod = {{LMUL_W{1'b0}}, w_q} * (OUT_W + LMUL_W)'(LOSS_TABLE_DEPTH);
    assign w_lidx = w_prod[OUT_W +: LIDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept || (r_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_activation <= i_item.act;
            r_loss       <= w_tab[w_lidx];
            r_saturated  <= i_item.sat;
        end
    end

    assign o_valid      = r_valid;
    assign o_activation = r_activation;
    assign o_loss       = r_loss;
    assign o_saturated  = r_saturated;

endmodule

### design/sigmoid_neuron_log_loss.sv
// Top level of the logistic regression neuron with binary log loss.
// Each input transaction carries one Q4.12 weight and one Q4.12 feature; their product is
// summed into a saturating 40-bit Q16.24 accumulator, and one transaction is accepted
// every clock cycle while the output does not stall, a rate set by the add and saturate
// loop of the accumulator. The transaction with tlast set closes the vector: a registered
// output transaction presents the sigmoid activation (Q0.16), the log loss for the label
// given in tuser (Q5.11) and a flag telling whether the accumulator saturated during the
// vector, and the accumulator starts the next vector from zero. Transactions without tlast
// produce no output. Both functions come from constant tables built at elaboration.
module sigmoid_neuron_log_loss #(
    parameter int unsigned SIGMOID_TABLE_DEPTH = snll_pkg::SIG_DEPTH_DEF,
    parameter int unsigned LOSS_TABLE_DEPTH    = snll_pkg::LOSS_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // weight [15:0], feature [31:16]
    input  logic        s_axis_tuser,   // label [0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // activation [15:0], loss [31:16]
    output logic        m_axis_tuser    // saturated [0]
);

    localparam int unsigned DATA_W = snll_pkg::DATA_W;
    localparam int unsigned OUT_W  = snll_pkg::OUT_W;

    logic                sum_valid;
    logic                sum_ready;
    snll_pkg::t_sum_item sum_item;
    logic                act_valid;
    logic                act_ready;
    snll_pkg::t_act_item act_item;
    logic [OUT_W-1:0]    w_activation;
    logic [OUT_W-1:0]    w_loss;

    snll_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_weight  (s_axis_tdata[DATA_W-1:0]),
        .i_feature (s_axis_tdata[2*DATA_W-1:DATA_W]),
        .i_label   (s_axis_tuser),
        .i_last    (s_axis_tlast),
        .o_valid   (sum_valid),
        .i_ready   (sum_ready),
        .o_item    (sum_item)
    );

    snll_sig #(
        .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_sig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sum_valid),
        .o_ready (sum_ready),
        .i_item  (sum_item),
        .o_valid (act_valid),
        .i_ready (act_ready),
        .o_item  (act_item)
    );

    snll_loss #(
        .LOSS_TABLE_DEPTH (LOSS_TABLE_DEPTH)
    ) u_loss (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (act_valid),
        .o_ready      (act_ready),
        .i_item       (act_item),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_activation (w_activation),
        .o_loss       (w_loss),
        .o_saturated  (m_axis_tuser)
    );

    assign m_axis_tdata = {w_loss, w_activation};

endmodule

### tb/sv/sigmoid_neuron_log_loss_tb.sv
// Self-checking testbench for the sigmoid neuron with log loss, driven over stream handshakes.
module sigmoid_neuron_log_loss_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIG_N       = snll_pkg::SIG_DEPTH_DEF;
    localparam int LOSS_N      = snll_pkg::LOSS_DEPTH_DEF;
    localparam int RAND_ITEMS  = 1800;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 600000;
    localparam int N_DIR       = 20;

    typedef logic [63:0] t_u64;
    localparam t_u64 ONE_Q62 = t_u64'(1) << 62;
    localparam longint SUM_HI = (longint'(1) << 39) - 1;
    localparam longint SUM_LO = -(longint'(1) << 39);

    typedef struct packed {
        logic signed [snll_pkg::DATA_W-1:0] weight;
        logic signed [snll_pkg::DATA_W-1:0] feature;
        logic                               label;
        logic                               last;
    } t_vec_item;

    typedef struct packed {
        logic [snll_pkg::OUT_W-1:0] act;
        logic [snll_pkg::OUT_W-1:0] loss;
        logic                       sat;
    } t_neuron_res;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] f;
        logic               label;
        logic               last;
        logic               typed;
        logic [15:0]        act;
        logic [15:0]        loss;
        logic               sat;
    } t_dir_row;

    t_dir_row dir_tab [N_DIR] = '{
        '{16'sd0, 16'sd0, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0},
        '{16'sd0, 16'sd0, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0},
        '{16'sh8000, 16'sh8000, 1'b1, 1'b1, 1'b1, 16'd65512, 16'd4, 1'b0},
        '{16'sh8000, 16'sh8000, 1'b0, 1'b1, 1'b1, 16'd65512, 16'd12776, 1'b0},
        '{16'sh8000, 16'sh7FFF, 1'b0, 1'b1, 1'b1, 16'd23, 16'd4, 1'b0},
        '{16'sh8000, 16'sh7FFF, 1'b1, 1'b1, 1'b1, 16'd23, 16'd12776, 1'b0},
        '{16'sd1, -16'sd1, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0},
        '{16'sd1024, 16'sd1024, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0},
        '{-16'sd1024, 16'sd1023, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0},
        '{16'sd16256, 16'sd8192, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0},
        '{-16'sd16384, 16'sd8192, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0},
        '{16'sd16384, 16'sd8192, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0},
        '{-16'sd16512, 16'sd8192, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0},
        '{16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
        '{16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
        '{16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
        '{-16'sd1, -16'sd1, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0},
        '{16'sh5555, 16'shAAAA, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
        '{16'shAAAA, 16'sh5555, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0},
        '{16'sd256, -16'sd256, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0}
    };

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // weight [15:0], feature [31:16]
    logic        s_axis_tuser  = 1'b0; // label [0]
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // activation [15:0], loss [31:16]
    logic        m_axis_tuser;         // saturated [0]

    logic [15:0] sig_lut  [SIG_N];
    logic [15:0] loss_lut [LOSS_N];
    longint      acc_sum;
    logic        acc_sat;

    t_neuron_res result_q [$];
    int          err_cnt    = 0;
    int          sent       = 0;
    int          n_vectors  = 0;
    int          n_sat      = 0;
    int          cycles     = 0;
    bit          calm       = 1'b0;
    bit          hold_req   = 1'b0;
    bit          hold_done  = 1'b0;

    sigmoid_neuron_log_loss u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("[sigmoid_neuron_log_loss] ERROR");
            $finish;
        end
    end

    function automatic t_u64 q62_mul(input t_u64 a, input t_u64 b);
        logic [127:0] wide;
        wide = 128'(a) * 128'(b);
        return t_u64'(wide >> 62);
    endfunction

    function automatic t_u64 q62_div(input t_u64 num, input t_u64 den);
        t_u64 sc;
        t_u64 hi;
        t_u64 rem;
        sc  = num << 31;
        hi  = sc / den;
        rem = sc % den;
        return (hi << 31) + ((rem << 31) / den);
    endfunction

    function automatic t_u64 q62_atanh(input t_u64 z);
        t_u64 zz;
        t_u64 pw;
        t_u64 acc;
        zz  = q62_mul(z, z);
        pw  = z;
        acc = '0;
        for (int k = 0; k < 32; k++) begin
            acc = acc + pw / t_u64'(2 * k + 1);
            pw  = q62_mul(pw, zz);
        end
        return acc;
    endfunction

    function automatic void build_luts();
        t_u64 e1;
        t_u64 term;
        t_u64 epow [SIG_N];
        t_u64 den;
        t_u64 quo;
        t_u64 v;
        t_u64 ln2;
        t_u64 a;
        t_u64 c;
        t_u64 sh;
        int   m2;
        int   m;
        e1   = ONE_Q62;
        term = ONE_Q62;
        for (int n = 1; n < 25; n++) begin
            term = term / t_u64'(32 * n);
            if (n % 2 == 1) begin
                e1 = e1 - term;
            end else begin
                e1 = e1 + term;
            end
        end
        epow[0] = ONE_Q62;
        for (int k = 1; k < SIG_N; k++) begin
            epow[k] = q62_mul(epow[k-1], e1);
        end
        for (int k = 0; k < SIG_N; k++) begin
            m2 = 2 * k - (SIG_N - 1);
            m  = (m2 < 0) ? -m2 : m2;
            if (m >= SIG_N) begin
                m = SIG_N - 1;
            end
            den = (ONE_Q62 + epow[m]) >> 30;
            quo = (t_u64'(65535) << 47) / den;
            if (m2 >= 0) begin
                v = (quo + (t_u64'(1) << 14)) >> 15;
            end else begin
                v = ((t_u64'(65535) << 15) - quo + (t_u64'(1) << 14)) >> 15;
            end
            sig_lut[k] = (v > t_u64'(65535)) ? 16'hFFFF : v[15:0];
        end
        ln2 = (q62_atanh(q62_div(t_u64'(1), t_u64'(3))) << 1) >> 22;
        for (int j = 0; j < LOSS_N; j++) begin
            a  = t_u64'(2 * LOSS_N);
            c  = t_u64'(2 * j + 1);
            sh = '0;
            while ((c << 1) <= a) begin
                c  = c << 1;
                sh = sh + t_u64'(1);
            end
            v = sh * ln2 + ((q62_atanh(q62_div(a - c, a + c)) << 1) >> 22);
            v = (v + (t_u64'(1) << 28)) >> 29;
            loss_lut[j] = (v > t_u64'(65535)) ? 16'hFFFF : v[15:0];
        end
    endfunction

    // Returns 1 when the transaction closes a vector and fills res with its outcome.
    function automatic bit neuron_predict(input t_vec_item it, output t_neuron_res res);
        longint      s;
        longint      six;
        longint      qi;
        logic [15:0] act;
        logic [15:0] q;
        s = acc_sum + longint'($signed(it.weight)) * longint'($signed(it.feature));
        if (s > SUM_HI) begin
            s       = SUM_HI;
            acc_sat = 1'b1;
        end
        if (s < SUM_LO) begin
            s       = SUM_LO;
            acc_sat = 1'b1;
        end
        acc_sum = s;
        res     = '0;
        if (!it.last) begin
            return 1'b0;
        end
        six = (s >>> 20) + SIG_N / 2;
        if (six < 0) begin
            six = 0;
        end
        if (six > SIG_N - 1) begin
            six = SIG_N - 1;
        end
        act      = sig_lut[six];
        q        = it.label ? act : 16'hFFFF - act;
        qi       = ((longint'(q) * LOSS_N) >> 16) % LOSS_N;
        res.act  = act;
        res.loss = loss_lut[qi];
        res.sat  = acc_sat;
        acc_sum  = 0;
        acc_sat  = 1'b0;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [15:0] draw_value(input int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 4))
                0: return 16'sh8000;
                1: return 16'sh7FFF;
                2: return 16'sh0000;
                3: return 16'shFFFF;
                default: return 16'sh0001;
            endcase
        end
        if (span >= 32768) begin
            return 16'($urandom_range(0, 65535));
        end
        return 16'($urandom_range(0, 2 * span - 1) - span);
    endfunction

    task automatic note_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic offer(input t_vec_item it, input bit typed, input t_neuron_res want);
        t_neuron_res res;
        int          gap;
        calm = ((sent / 200) % 5) == 4;
        gap  = calm ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.feature, it.weight};
        s_axis_tuser  <= it.label;
        s_axis_tlast  <= it.last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (neuron_predict(it, res)) begin
            if (typed) begin
                res = want;
            end
            result_q.push_back(res);
            n_vectors++;
            if (res.sat) begin
                n_sat++;
            end
        end
        sent++;
        @(negedge i_clk);
    endtask

    // Long saturating vector: max-size products push the sum past its limit,
    // then a few products of the opposite sign must not clear the flag.
    task automatic saturate_run(input bit go_high);
        t_vec_item it;
        for (int i = 0; i < 519; i++) begin
            it.weight = 16'sh8000;
            it.label  = 1'($urandom_range(0, 1));
            it.last   = (i == 518);
            if (i < 516) begin
                it.feature = go_high ? 16'sh8000 : 16'sh7FFF;
            end else begin
                it.feature = go_high ? 16'($urandom_range(1, 32767))
                                     : 16'(-$urandom_range(1, 32767));
            end
            offer(it, 1'b0, '0);
        end
    endtask

    initial begin
        t_vec_item   it;
        t_neuron_res want;
        int          len;
        int          w_span;
        int          f_span;
        bit          high_done;
        bit          low_done;
        high_done = 1'b0;
        low_done  = 1'b0;
        acc_sum   = 0;
        acc_sat   = 1'b0;
        build_luts();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            it.weight  = dir_tab[i].w;
            it.feature = dir_tab[i].f;
            it.label   = dir_tab[i].label;
            it.last    = dir_tab[i].last;
            want.act   = dir_tab[i].act;
            want.loss  = dir_tab[i].loss;
            want.sat   = dir_tab[i].sat;
            offer(it, dir_tab[i].typed, want);
        end

        while (sent < N_DIR + RAND_ITEMS) begin
            if (sent > N_DIR + 150) begin
                hold_req = 1'b1;
            end
            if (!high_done && sent > N_DIR + 300) begin
                high_done = 1'b1;
                saturate_run(1'b1);
            end else if (!low_done && sent > N_DIR + 900) begin
                low_done = 1'b1;
                saturate_run(1'b0);
            end else begin
                len    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
                w_span = ($urandom_range(0, 2) == 0) ? 32768 : 256 << $urandom_range(0, 4);
                f_span = ($urandom_range(0, 2) == 0) ? 32768 : 256 << $urandom_range(0, 4);
                for (int k = 0; k < len; k++) begin
                    it.weight  = draw_value(w_span);
                    it.feature = draw_value(f_span);
                    it.label   = 1'($urandom_range(0, 1));
                    it.last    = (k == len - 1);
                    offer(it, 1'b0, '0);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (result_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Covered %0d input transactions closing %0d vectors, %0d of them saturated.",
                 sent, n_vectors, n_sat);
        $display("Table edges, both labels, long input and output stalls were exercised.");
        if (err_cnt == 0) begin
            $display("[sigmoid_neuron_log_loss] OK");
        end else begin
            $display("[sigmoid_neuron_log_loss] ERROR");
        end
        $finish;
    end

    initial begin : sink_ready
        int  stall_left;
        bit  rdy_next;
        stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                rdy_next = 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                rdy_next   = 1'b0;
            end else begin
                stall_left = calm ? 0 : pick_gap();
                if (stall_left != 0) begin
                    stall_left--;
                    rdy_next = 1'b0;
                end else begin
                    rdy_next = 1'b1;
                end
            end
            m_axis_tready <= rdy_next;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_neuron_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                note_mismatch($sformatf("result with nothing pending, activation %0d",
                                        m_axis_tdata[15:0]));
            end else begin
                want = result_q.pop_front();
                if (m_axis_tdata[15:0] !== want.act) begin
                    note_mismatch($sformatf("activation got %0d want %0d",
                                            m_axis_tdata[15:0], want.act));
                end
                if (m_axis_tdata[31:16] !== want.loss) begin
                    note_mismatch($sformatf("loss got %0d want %0d",
                                            m_axis_tdata[31:16], want.loss));
                end
                if (m_axis_tuser !== want.sat) begin
                    note_mismatch($sformatf("saturated got %0b want %0b",
                                            m_axis_tuser, want.sat));
                end
            end
        end
    end

endmodule
